// ===== rtl/core/prp_pkg.sv =====
package prp_pkg;

  localparam int COORD_W    = 24;
  localparam int TRIG_W     = 16;
  localparam int TRIG_FRAC  = 14;
  localparam int ISO_FRAC   = 15;
  localparam int VIEW_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int PIPE_DEPTH = 8;

  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ISO_W  = COORD_W + 1 + TRIG_W;
  localparam int YD_W   = COORD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [ISO_W-1:0]   iso_t;
  typedef logic signed [YD_W-1:0]    ydiff_t;

  localparam trig_t ISO_COS30 = TRIG_W'(28378);
  localparam trig_t TRIG_ONE  = TRIG_W'(1 << TRIG_FRAC);
  localparam trig_t TRIG_ZERO = '0;

  localparam sum_t COORD_HI = sum_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam sum_t COORD_LO = -COORD_HI - sum_t'(1);

  typedef enum logic [VIEW_W-1:0] {
    VIEW_ISO   = 2'd0,
    VIEW_FRONT = 2'd1,
    VIEW_TOP   = 2'd2,
    VIEW_SIDE  = 2'd3
  } view_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5,
    REG_VIEW  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    trig_t cos_x;
    trig_t sin_x;
    trig_t cos_y;
    trig_t sin_y;
    trig_t cos_z;
    trig_t sin_z;
    view_e view;
  } cfg_t;

  function automatic coord_t sat_coord(input sum_t v);
    coord_t r;
    if (v > COORD_HI) begin
      r = COORD_HI[COORD_W-1:0];
    end else if (v < COORD_LO) begin
      r = COORD_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic coord_t rot_round(input prod_t p1, input prod_t p2, input logic sub);
    sum_t s;
    s = sum_t'(p1) + (sub ? -sum_t'(p2) : sum_t'(p2)) + (sum_t'(1) <<< (TRIG_FRAC - 1));
    return sat_coord(s >>> TRIG_FRAC);
  endfunction

endpackage

// ===== rtl/core/prp_if.sv =====
interface prp_cfg_if;
  import prp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TRIG_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface prp_pt_if;
  import prp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface prp_scr_if;
  import prp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t screen_x;
  coord_t screen_y;
  modport source (output valid, output screen_x, output screen_y, input ready);
  modport sink (input valid, input screen_x, input screen_y, output ready);
endinterface

// ===== rtl/core/point_rotate_project.sv =====
// point rotation (x, then y, then z axis) and 2d projection
// 8 register stages between a taken request and its result
// throughput: one request per cycle while the output is not stalled, eight register stages in a line
// a stalled output freezes the whole pipeline, nothing lost or repeated
// reset: async active low, clears valid bits, trig registers to identity, view isometric
module point_rotate_project (
  input  logic            clk_i,
  input  logic            rst_ni,
  prp_cfg_if.sink         cfg_i,
  prp_pt_if.sink          pt_i,
  prp_scr_if.source       res_o
);
  import prp_pkg::*;

  cfg_t                  cfg_q;
  logic [PIPE_DEPTH-1:0] v_q;
  logic                  en;

  coord_t x1_q;
  prod_t  p1a_q, p1b_q, p1c_q, p1d_q;
  coord_t x2_q, y2_q, z2_q;
  coord_t y3_q;
  prod_t  p3a_q, p3b_q, p3c_q, p3d_q;
  coord_t x4_q, y4_q, z4_q;
  coord_t z5_q;
  prod_t  p5a_q, p5b_q, p5c_q, p5d_q;
  coord_t x6_q, y6_q, z6_q;
  iso_t   iso_q;
  ydiff_t yd_q;
  coord_t selx_q, sely_q;
  view_e  view7_q;
  coord_t sx_q, sy_q;

  logic signed [COORD_W:0] dxz;
  ydiff_t                  yd_d;
  coord_t                  selx_d, sely_d;
  coord_t                  sx_d, sy_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_x <= TRIG_ONE;
      cfg_q.sin_x <= TRIG_ZERO;
      cfg_q.cos_y <= TRIG_ONE;
      cfg_q.sin_y <= TRIG_ZERO;
      cfg_q.cos_z <= TRIG_ONE;
      cfg_q.sin_z <= TRIG_ZERO;
      cfg_q.view  <= VIEW_ISO;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_COS_X: cfg_q.cos_x <= trig_t'(cfg_i.data);
        REG_SIN_X: cfg_q.sin_x <= trig_t'(cfg_i.data);
        REG_COS_Y: cfg_q.cos_y <= trig_t'(cfg_i.data);
        REG_SIN_Y: cfg_q.sin_y <= trig_t'(cfg_i.data);
        REG_COS_Z: cfg_q.cos_z <= trig_t'(cfg_i.data);
        REG_SIN_Z: cfg_q.sin_z <= trig_t'(cfg_i.data);
        REG_VIEW:  cfg_q.view  <= view_e'(cfg_i.data[VIEW_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline moves unless the output holds a result not yet taken
  assign en          = !v_q[PIPE_DEPTH-1] || res_o.ready;
  assign pt_i.ready  = en;
  assign res_o.valid = v_q[PIPE_DEPTH-1];
  assign res_o.screen_x = sx_q;
  assign res_o.screen_y = sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], pt_i.valid};
    end
  end

  always_comb begin
    dxz = (COORD_W+1)'(x6_q) - (COORD_W+1)'(z6_q);
    yd_d = (YD_W'(y6_q) <<< 1) - YD_W'(x6_q) - YD_W'(z6_q);
    unique case (cfg_q.view)
      VIEW_TOP: begin
        selx_d = x6_q;
        sely_d = z6_q;
      end
      VIEW_SIDE: begin
        selx_d = z6_q;
        sely_d = y6_q;
      end
      default: begin
        selx_d = x6_q;
        sely_d = y6_q;
      end
    endcase
  end

  always_comb begin
    unique case (view7_q)
      VIEW_ISO: begin
        sx_d = sat_coord((sum_t'(iso_q) + (sum_t'(1) <<< (ISO_FRAC - 1))) >>> ISO_FRAC);
        sy_d = sat_coord((sum_t'(yd_q) + sum_t'(1)) >>> 1);
      end
      default: begin
        sx_d = selx_q;
        sy_d = sely_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // x axis
      x1_q  <= pt_i.pos_x;
      p1a_q <= pt_i.pos_y * cfg_q.cos_x;
      p1b_q <= pt_i.pos_z * cfg_q.sin_x;
      p1c_q <= pt_i.pos_y * cfg_q.sin_x;
      p1d_q <= pt_i.pos_z * cfg_q.cos_x;
      x2_q  <= x1_q;
      y2_q  <= rot_round(p1a_q, p1b_q, 1'b1);
      z2_q  <= rot_round(p1c_q, p1d_q, 1'b0);
      // y axis
      y3_q  <= y2_q;
      p3a_q <= x2_q * cfg_q.cos_y;
      p3b_q <= z2_q * cfg_q.sin_y;
      p3c_q <= z2_q * cfg_q.cos_y;
      p3d_q <= x2_q * cfg_q.sin_y;
      x4_q  <= rot_round(p3a_q, p3b_q, 1'b0);
      y4_q  <= y3_q;
      z4_q  <= rot_round(p3c_q, p3d_q, 1'b1);
      // z axis
      z5_q  <= z4_q;
      p5a_q <= x4_q * cfg_q.cos_z;
      p5b_q <= y4_q * cfg_q.sin_z;
      p5c_q <= x4_q * cfg_q.sin_z;
      p5d_q <= y4_q * cfg_q.cos_z;
      x6_q  <= rot_round(p5a_q, p5b_q, 1'b1);
      y6_q  <= rot_round(p5c_q, p5d_q, 1'b0);
      z6_q  <= z5_q;
      // projection
      iso_q   <= dxz * ISO_COS30;
      yd_q    <= yd_d;
      selx_q  <= selx_d;
      sely_q  <= sely_d;
      view7_q <= cfg_q.view;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
    end
  end

endmodule

// ===== rtl/core/prp_checker.sv =====
module prp_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input prp_pkg::coord_t out_x_i,
  input prp_pkg::coord_t out_y_i
);
  import prp_pkg::*;

  // a result waiting on the output keeps its values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i))
    else $error("stalled result changed");

  // new requests are refused only while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("request ready does not follow output stall");

  // reset empties the pipeline
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");

  // an idle input for a full pipeline depth with no stall drains the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && out_ready_i ##1 !in_valid_i && out_ready_i ##1 !in_valid_i && out_ready_i
      ##1 !in_valid_i && out_ready_i ##1 !in_valid_i && out_ready_i
      ##1 !in_valid_i && out_ready_i ##1 !in_valid_i && out_ready_i
      ##1 !in_valid_i && out_ready_i |=> !out_valid_i)
    else $error("result without a request");

endmodule

bind point_rotate_project prp_checker u_prp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_x_i     (res_o.screen_x),
  .out_y_i     (res_o.screen_y)
);

// ===== tb/sv/projection_check.sv =====
`timescale 1ns / 1ps

module projection_check (
  input  logic   clk_i,
  input  logic   rst_ni,
  prp_cfg_if     cfg_i,
  prp_pt_if      pt_i,
  prp_scr_if     res_i,
  output int     mismatches_o,
  output int     outstanding_o,
  output int     compared_o
);
  import prp_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct {
    coord_t sx;
    coord_t sy;
  } screen_pt_t;

  cfg_t       shadow;
  screen_pt_t expected_screen_q[$];
  int         mismatch_count;
  int         compare_count;

  assign mismatches_o = mismatch_count;
  assign compared_o   = compare_count;

  function automatic longint clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // round to nearest, ties towards plus infinity
  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint rotate_term(input longint a, input longint c,
                                         input longint b, input longint s);
    return clamp_coord(round_shift(a * c + b * s, TRIG_FRAC));
  endfunction

  function automatic screen_pt_t project_point(input cfg_t k, input coord_t px,
                                               input coord_t py, input coord_t pz);
    longint     x;
    longint     y;
    longint     z;
    longint     t0;
    longint     t1;
    screen_pt_t r;
    x = px;
    y = py;
    z = pz;
    // x axis
    t0 = rotate_term(y, k.cos_x, z, -longint'(k.sin_x));
    t1 = rotate_term(y, k.sin_x, z, k.cos_x);
    y = t0;
    z = t1;
    // y axis
    t0 = rotate_term(x, k.cos_y, z, k.sin_y);
    t1 = rotate_term(z, k.cos_y, x, -longint'(k.sin_y));
    x = t0;
    z = t1;
    // z axis
    t0 = rotate_term(x, k.cos_z, y, -longint'(k.sin_z));
    t1 = rotate_term(x, k.sin_z, y, k.cos_z);
    x = t0;
    y = t1;
    case (k.view)
      VIEW_ISO: begin
        r.sx = coord_t'(clamp_coord(round_shift((x - z) * longint'(ISO_COS30), ISO_FRAC)));
        r.sy = coord_t'(clamp_coord(round_shift(2 * y - (x + z), 1)));
      end
      VIEW_TOP: begin
        r.sx = coord_t'(x);
        r.sy = coord_t'(z);
      end
      VIEW_SIDE: begin
        r.sx = coord_t'(z);
        r.sy = coord_t'(y);
      end
      default: begin
        r.sx = coord_t'(x);
        r.sy = coord_t'(y);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input coord_t got, input coord_t want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: %s: got %0d expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    compare_count  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    screen_pt_t want;
    if (!rst_ni) begin
      shadow = '{cos_x: TRIG_ONE, sin_x: TRIG_ZERO, cos_y: TRIG_ONE, sin_y: TRIG_ZERO,
                 cos_z: TRIG_ONE, sin_z: TRIG_ZERO, view: VIEW_ISO};
      expected_screen_q.delete();
      outstanding_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_screen_q.size() == 0) begin
          report_mismatch("result with nothing pending", res_i.screen_x, '0);
        end else begin
          want = expected_screen_q.pop_front();
          if (res_i.screen_x !== want.sx) begin
            report_mismatch("screen_x", res_i.screen_x, want.sx);
          end
          if (res_i.screen_y !== want.sy) begin
            report_mismatch("screen_y", res_i.screen_y, want.sy);
          end
          compare_count++;
        end
      end
      if (pt_i.valid && pt_i.ready) begin
        expected_screen_q.push_back(project_point(shadow, pt_i.pos_x, pt_i.pos_y, pt_i.pos_z));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_COS_X: shadow.cos_x = cfg_i.data;
          REG_SIN_X: shadow.sin_x = cfg_i.data;
          REG_COS_Y: shadow.cos_y = cfg_i.data;
          REG_SIN_Y: shadow.sin_y = cfg_i.data;
          REG_COS_Z: shadow.cos_z = cfg_i.data;
          REG_SIN_Z: shadow.sin_z = cfg_i.data;
          REG_VIEW:  shadow.view  = view_e'(cfg_i.data[VIEW_W-1:0]);
          default: ;
        endcase
      end
      outstanding_o <= expected_screen_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import prp_pkg::*;

  localparam int HANG_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1250;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
  localparam logic [6:0] ALL_REGS  = '1;
  localparam logic [6:0] VIEW_ONLY = 7'(1) << REG_VIEW;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   quiet_cycles;
  int   points_sent;
  int   settings_loaded;
  int   mismatches;
  int   outstanding;
  int   compared;

  prp_cfg_if cfg_bus ();
  prp_pt_if  pt_bus ();
  prp_scr_if scr_bus ();

  point_rotate_project DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .pt_i   (pt_bus),
    .res_o  (scr_bus)
  );

  projection_check u_projection_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_i         (cfg_bus),
    .pt_i          (pt_bus),
    .res_i         (scr_bus),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic int draw_gap();
    if (no_gaps) begin
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic trig_t pick_trig();
    case ($urandom_range(0, 7))
      0: return TRIG_ONE;
      1: return -TRIG_ONE;
      2: return TRIG_ZERO;
      3: return trig_t'($urandom);
      default: return trig_t'($urandom_range(0, 32768)) - TRIG_ONE;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TRIG_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // nothing in flight once every pending result has been taken
  task automatic wait_idle();
    pt_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apply_setting(input trig_t cx, input trig_t sx, input trig_t cy,
                               input trig_t sy, input trig_t cz, input trig_t sz,
                               input logic [TRIG_W-1:0] view_word,
                               input logic [6:0] mask, input bit stray);
    wait_idle();
    if (mask[REG_COS_X]) write_reg(REG_COS_X, cx);
    if (mask[REG_SIN_X]) write_reg(REG_SIN_X, sx);
    if (mask[REG_COS_Y]) write_reg(REG_COS_Y, cy);
    if (stray) write_reg(REG_UNUSED, TRIG_W'($urandom));
    if (mask[REG_SIN_Y]) write_reg(REG_SIN_Y, sy);
    if (mask[REG_COS_Z]) write_reg(REG_COS_Z, cz);
    if (mask[REG_SIN_Z]) write_reg(REG_SIN_Z, sz);
    if (mask[REG_VIEW])  write_reg(REG_VIEW, view_word);
    cfg_bus.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      pt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_bus.valid <= 1'b1;
    pt_bus.pos_x <= x;
    pt_bus.pos_y <= y;
    pt_bus.pos_z <= z;
    do @(posedge clk); while (!pt_bus.ready);
    points_sent++;
  endtask

  // result side back-pressure
  initial begin
    int gap;
    scr_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        scr_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      scr_bus.ready <= 1'b1;
      do @(posedge clk); while (!scr_bus.valid);
    end
  end

  always @(posedge clk) begin
    if ((pt_bus.valid && pt_bus.ready) || (scr_bus.valid && scr_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("hang: no request or result moved for %0d cycles", HANG_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n = 1'b0;
    quiet_cycles = 0;
    points_sent = 0;
    settings_loaded = 0;
    no_gaps = 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    pt_bus.valid  <= 1'b0;
    pt_bus.pos_x  <= '0;
    pt_bus.pos_y  <= '0;
    pt_bus.pos_z  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // identity rotation, isometric, rounding ties and saturation
    apply_setting(TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO,
                  TRIG_W'(VIEW_ISO), ALL_REGS, 1'b0);
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, '0, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX);
    send_point(coord_t'(1), '0, '0);
    send_point('0, '0, coord_t'(1));

    // quarter, half and eighth turns, front view
    apply_setting(TRIG_ZERO, TRIG_ONE, -TRIG_ONE, TRIG_ZERO, trig_t'(11585), trig_t'(-11585),
                  TRIG_W'(VIEW_FRONT), ALL_REGS, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(coord_t'(1), coord_t'(1), coord_t'(1));
    send_point(coord_t'(-3), coord_t'(5), coord_t'(7));
    send_point(COORD_MIN, COORD_MIN, '0);

    // trig patterns beyond unity, top view, stray register index
    apply_setting(trig_t'(16'h7fff), trig_t'(16'h8000), trig_t'(16'h8000),
                  trig_t'(16'h7fff), trig_t'(16'h7fff), trig_t'(16'h8000),
                  TRIG_W'(VIEW_TOP), ALL_REGS, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(coord_t'(100), coord_t'(-200), coord_t'(300));
    send_point('0, coord_t'(1), coord_t'(-1));

    // thirty and sixty degree angles and a half turn, side view
    apply_setting(trig_t'(14189), trig_t'(8192), trig_t'(8192), trig_t'(-14189),
                  -TRIG_ONE, TRIG_ZERO, TRIG_W'(VIEW_SIDE), ALL_REGS, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN);
    send_point(coord_t'(12345), coord_t'(-6789), coord_t'(2222));
    send_point(COORD_MIN, '0, COORD_MAX);

    // view written with upper bits set, only the low two count
    apply_setting(TRIG_ZERO, TRIG_ZERO, TRIG_ZERO, TRIG_ZERO, TRIG_ZERO, TRIG_ZERO,
                  TRIG_W'(16'hfff9), VIEW_ONLY, 1'b1);
    send_point(COORD_MAX, coord_t'(1), COORD_MIN);
    send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_point(coord_t'(77), coord_t'(88), coord_t'(99));

    n = points_sent + RANDOM_ITEMS;
    while (points_sent < n) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      apply_setting(pick_trig(), pick_trig(), pick_trig(), pick_trig(), pick_trig(),
                    pick_trig(), TRIG_W'($urandom), 7'($urandom),
                    ($urandom_range(0, 5) == 0));
      repeat ($urandom_range(20, 120)) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
      end
    end

    wait_idle();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("%0d points sent under %0d register settings, %0d screen results compared",
             points_sent, settings_loaded, compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
